### rtl/cba_pkg.sv
`timescale 1ns / 1ps

package cba_pkg;

  // Built size of the disk and of the file directory.
  localparam int unsigned BLOCKS      = 32;
  localparam int unsigned DIR_ENTRIES = 16;

  // Field widths of the request and response items.
  localparam int unsigned ID_W     = 16;
  localparam int unsigned START_W  = 5;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned FREE_W   = 6;
  localparam int unsigned DISK_W   = 6;
  localparam int unsigned STATUS_W = 2;

  localparam logic [DISK_W-1:0] DISK_RESET = 6'd32;

  // Derived widths.
  localparam int unsigned CNT_W     = $clog2(BLOCKS + 1);
  localparam int unsigned IDX_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned FC_W      = $clog2(DIR_ENTRIES + 1);
  localparam int unsigned DIR_IDX_W = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int unsigned CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  // The free counter walks the map four blocks per cycle.
  localparam int unsigned LANES  = 4;
  localparam int unsigned LANE_W = 2;
  localparam int unsigned STEPS  = (BLOCKS + LANES - 1) / LANES;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_DIR_FULL  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } dir_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FIND_RD,
    S_FIND_CMP,
    S_FREE,
    S_SH_RD,
    S_SH_WR,
    S_COUNT,
    S_RESP
  } state_e;

endpackage

### rtl/contiguous_block_allocator.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake             Payload
// request    in         start high, busy low  kind_i, file_id_i, block_count_i
// response   out        done_o, one cycle     status_o, base_block_o, run_length_o,
//                                             free_blocks_o
// config     in         cfg_we_i              cfg_data_i (disk_blocks)
//
// A create scans the map one block at a time for a first free run, marks the run and
// writes its entry, counts the free blocks four at a time, then responds; a full
// directory or a zero count skips the scan. A delete reads and compares each entry to
// find the id, frees its run, moves later entries down, then counts and responds.
// Reset clears the free map, the file count and the state; disk_blocks returns to 32.
// busy stays high from the accepted item until the cycle after done_o.
// The receiver cannot stall: each result is shown for exactly one cycle.

module contiguous_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [cba_pkg::ID_W-1:0]      file_id_i,
  input  logic [cba_pkg::LEN_W-1:0]     block_count_i,
  output logic                          done_o,
  output logic [cba_pkg::STATUS_W-1:0]  status_o,
  output logic [cba_pkg::START_W-1:0]   base_block_o,
  output logic [cba_pkg::LEN_W-1:0]     run_length_o,
  output logic [cba_pkg::FREE_W-1:0]    free_blocks_o,
  input  logic                          cfg_we_i,
  input  logic [cba_pkg::DISK_W-1:0]    cfg_data_i
);

  cba_pkg::state_e state_q, state_d;

  // Control state, set by reset: map and file count clear, disk_blocks returns to 32.
  logic [cba_pkg::DISK_W-1:0] disk_q;
  logic [cba_pkg::BLOCKS-1:0] map_q;
  logic [cba_pkg::FC_W-1:0]   fc_q;

  // Request and working registers.
  logic [cba_pkg::ID_W-1:0]      id_q;
  logic [cba_pkg::LEN_W-1:0]     req_q;
  logic [cba_pkg::CNT_W-1:0]     scan_q;
  logic [cba_pkg::CNT_W-1:0]     run_q;
  logic [cba_pkg::START_W-1:0]   run_start_q;
  logic [cba_pkg::LEN_W-1:0]     run_len_q;
  cba_pkg::status_e              status_q;
  logic [cba_pkg::FC_W-1:0]      dir_idx_q;
  logic [cba_pkg::STEP_W-1:0]    step_q;
  logic [cba_pkg::CNT_W-1:0]     free_q;

  // Directory memory with a registered read port.
  cba_pkg::dir_entry_t           dir_mem [cba_pkg::DIR_ENTRIES];
  cba_pkg::dir_entry_t           rd_q;
  logic                          mem_we;
  logic [cba_pkg::DIR_IDX_W-1:0] mem_waddr;
  logic [cba_pkg::DIR_IDX_W-1:0] mem_raddr;
  cba_pkg::dir_entry_t           mem_wdata;

  logic                                      accept;
  logic [cba_pkg::CNT_W-1:0]                 n_used;
  logic                                      scan_end;
  logic                                      scan_bit;
  logic [cba_pkg::CNT_W-1:0]                 run_inc;
  logic                                      hit;
  logic [cba_pkg::BLOCKS-1:0]                run_mask;
  logic [cba_pkg::FC_W-1:0]                  dir_next;
  logic                                      id_match;
  logic [cba_pkg::STEPS*cba_pkg::LANES-1:0]  map_pad;
  logic [cba_pkg::LANE_W:0]                  cnt_add;
  logic                                      count_last;

  assign accept = start && (state_q == cba_pkg::S_IDLE);

  // Blocks in use: disk_blocks saturated at the built size.
  assign n_used = (disk_q > cba_pkg::DISK_W'(cba_pkg::BLOCKS)) ?
                  cba_pkg::CNT_W'(cba_pkg::BLOCKS) : cba_pkg::CNT_W'(disk_q);

  // First-fit scan: one block per cycle, tracking the current free run.
  assign scan_end = (scan_q >= n_used);
  assign scan_bit = map_q[scan_q[cba_pkg::IDX_W-1:0]];
  assign run_inc  = run_q + 1'b1;
  assign hit      = !scan_bit &&
                    (cba_pkg::CMP_W'(run_inc) >= cba_pkg::CMP_W'(req_q));

  // The run held in run_start_q/run_len_q as a mask, used both to mark an
  // allocation and to free a deleted file.
  always_comb begin
    for (int j = 0; j < cba_pkg::BLOCKS; j++) begin
      run_mask[j] = (j >= int'(run_start_q)) &&
                    (j < int'(run_start_q) + int'(run_len_q));
    end
  end

  assign dir_next = dir_idx_q + 1'b1;
  assign id_match = (rd_q.id == id_q);

  // Free counter: four blocks of the map per cycle, only below n_used.
  assign map_pad = (cba_pkg::STEPS * cba_pkg::LANES)'(map_q);

  always_comb begin
    cnt_add = '0;
    for (int b = 0; b < cba_pkg::LANES; b++) begin
      if ((int'(step_q) * cba_pkg::LANES + b < int'(n_used)) &&
          !map_pad[{step_q, cba_pkg::LANE_W'(b)}]) begin
        cnt_add = cnt_add + 1'b1;
      end
    end
  end

  assign count_last = (step_q == cba_pkg::STEP_W'(cba_pkg::STEPS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cba_pkg::S_IDLE: begin
        if (accept) begin
          if (kind_i == cba_pkg::KIND_DELETE) begin
            state_d = cba_pkg::S_FIND_RD;
          end else if (fc_q >= cba_pkg::FC_W'(cba_pkg::DIR_ENTRIES)) begin
            state_d = cba_pkg::S_COUNT;
          end else if (block_count_i == '0) begin
            state_d = cba_pkg::S_COUNT;
          end else begin
            state_d = cba_pkg::S_SCAN;
          end
        end
      end
      cba_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = cba_pkg::S_COUNT;
        end else if (hit) begin
          state_d = cba_pkg::S_MARK;
        end
      end
      cba_pkg::S_MARK: begin
        state_d = cba_pkg::S_COUNT;
      end
      cba_pkg::S_FIND_RD: begin
        if (dir_idx_q >= fc_q) begin
          state_d = cba_pkg::S_COUNT;
        end else begin
          state_d = cba_pkg::S_FIND_CMP;
        end
      end
      cba_pkg::S_FIND_CMP: begin
        if (id_match) begin
          state_d = cba_pkg::S_FREE;
        end else begin
          state_d = cba_pkg::S_FIND_RD;
        end
      end
      cba_pkg::S_FREE: begin
        state_d = cba_pkg::S_SH_RD;
      end
      cba_pkg::S_SH_RD: begin
        if (dir_next < fc_q) begin
          state_d = cba_pkg::S_SH_WR;
        end else begin
          state_d = cba_pkg::S_COUNT;
        end
      end
      cba_pkg::S_SH_WR: begin
        state_d = cba_pkg::S_SH_RD;
      end
      cba_pkg::S_COUNT: begin
        if (count_last) begin
          state_d = cba_pkg::S_RESP;
        end
      end
      cba_pkg::S_RESP: begin
        state_d = cba_pkg::S_IDLE;
      end
      default: begin
        state_d = cba_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and memory control decoded from the state.
  always_comb begin
    busy      = (state_q != cba_pkg::S_IDLE);
    done_o    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = fc_q[cba_pkg::DIR_IDX_W-1:0];
    mem_wdata = '{id: id_q, start: run_start_q, len: req_q};
    mem_raddr = dir_idx_q[cba_pkg::DIR_IDX_W-1:0];
    case (state_q)
      cba_pkg::S_MARK: begin
        mem_we = 1'b1;
      end
      cba_pkg::S_SH_RD: begin
        mem_raddr = dir_next[cba_pkg::DIR_IDX_W-1:0];
      end
      cba_pkg::S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dir_idx_q[cba_pkg::DIR_IDX_W-1:0];
        mem_wdata = rd_q;
      end
      cba_pkg::S_RESP: begin
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status_o      = status_q;
  assign base_block_o  = run_start_q;
  assign run_length_o  = run_len_q;
  assign free_blocks_o = cba_pkg::FREE_W'(free_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cba_pkg::S_IDLE;
      disk_q  <= cba_pkg::DISK_RESET;
      map_q   <= '0;
      fc_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        disk_q <= cfg_data_i;
      end
      if (state_q == cba_pkg::S_MARK) begin
        map_q <= map_q | run_mask;
        fc_q  <= fc_q + 1'b1;
      end
      if (state_q == cba_pkg::S_FREE) begin
        map_q <= map_q & ~run_mask;
      end
      if ((state_q == cba_pkg::S_SH_RD) && !(dir_next < fc_q)) begin
        fc_q <= fc_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cba_pkg::S_IDLE: begin
        if (accept) begin
          id_q        <= file_id_i;
          req_q       <= block_count_i;
          scan_q      <= '0;
          run_q       <= '0;
          dir_idx_q   <= '0;
          step_q      <= '0;
          free_q      <= '0;
          run_start_q <= '0;
          run_len_q   <= '0;
          // Start from the failure code; success overwrites it.
          if (kind_i == cba_pkg::KIND_DELETE) begin
            status_q <= cba_pkg::ST_NOT_FOUND;
          end else if (fc_q >= cba_pkg::FC_W'(cba_pkg::DIR_ENTRIES)) begin
            status_q <= cba_pkg::ST_DIR_FULL;
          end else begin
            status_q <= cba_pkg::ST_NO_SPACE;
          end
        end
      end
      cba_pkg::S_SCAN: begin
        if (!scan_end) begin
          scan_q <= scan_q + 1'b1;
          if (scan_bit) begin
            run_q <= '0;
          end else begin
            if (run_q == '0) begin
              run_start_q <= cba_pkg::START_W'(scan_q);
            end
            run_q <= run_inc;
            if (hit) begin
              status_q  <= cba_pkg::ST_OK;
              run_len_q <= req_q;
            end
          end
        end else begin
          // No run was long enough, so a partial run start must not be reported.
          run_start_q <= '0;
        end
      end
      cba_pkg::S_FIND_CMP: begin
        if (id_match) begin
          run_start_q <= rd_q.start;
          run_len_q   <= rd_q.len;
          status_q    <= cba_pkg::ST_OK;
        end else begin
          dir_idx_q <= dir_next;
        end
      end
      cba_pkg::S_SH_WR: begin
        dir_idx_q <= dir_next;
      end
      cba_pkg::S_COUNT: begin
        free_q <= free_q + cba_pkg::CNT_W'(cnt_add);
        step_q <= step_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dir_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= dir_mem[mem_raddr];
  end

endmodule

### rtl/cba_checker.sv
`timescale 1ns / 1ps

module cba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          kind_i,
  input logic [cba_pkg::ID_W-1:0]      file_id_i,
  input logic [cba_pkg::LEN_W-1:0]     block_count_i,
  input logic                          done_o,
  input logic [cba_pkg::STATUS_W-1:0]  status_o,
  input logic [cba_pkg::START_W-1:0]   base_block_o,
  input logic [cba_pkg::LEN_W-1:0]     run_length_o,
  input logic [cba_pkg::FREE_W-1:0]    free_blocks_o,
  input logic                          cfg_we_i,
  input logic [cba_pkg::DISK_W-1:0]    cfg_data_i
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

  // A result is a single-cycle strobe while busy, and the block is free after it.
  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 (!done_o && !busy))
    else $error("result strobe not a single cycle ending the item");

  // A failed request reports neither a start nor a length.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != cba_pkg::ST_OK) |-> (base_block_o == '0) && (run_length_o == '0))
    else $error("failed request reports a run");

  // A successful request always moves at least one block.
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == cba_pkg::ST_OK) |-> (run_length_o != '0))
    else $error("successful request with empty run");

  // The free count never exceeds the built size.
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (free_blocks_o <= cba_pkg::FREE_W'(cba_pkg::BLOCKS)))
    else $error("free block count out of range");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (.*);
